// File: design/tlsch_pkg.sv
`timescale 1ns / 1ps
package tlsch_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0]  CONTENT_HANDSHAKE = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO   = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME   = 16'h0000;
  localparam logic [15:0] EXT_GROUPS        = 16'h000a;
  localparam logic [15:0] RANDOM_LEN        = 16'd32;

  localparam logic [15:0] HYB_ID_FIRST_RST  = 16'hfe30;
  localparam logic [15:0] HYB_ID_SECOND_RST = 16'hfe31;
  localparam logic [15:0] HYB_ID_THIRD_RST  = 16'hfe32;
  localparam logic [2:0]  HYB_LVL_FIRST_RST  = 3'd3;
  localparam logic [2:0]  HYB_LVL_SECOND_RST = 3'd1;
  localparam logic [2:0]  HYB_LVL_THIRD_RST  = 3'd5;

  typedef enum logic [2:0] {
    REG_ID_FIRST   = 3'd0,
    REG_LVL_FIRST  = 3'd1,
    REG_ID_SECOND  = 3'd2,
    REG_LVL_SECOND = 3'd3,
    REG_ID_THIRD   = 3'd4,
    REG_LVL_THIRD  = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_VERSION = 3'd0,
    KIND_SUITE   = 3'd1,
    KIND_SNI     = 3'd2,
    KIND_GROUP   = 3'd3,
    KIND_SUMMARY = 3'd4
  } kind_t;

  typedef enum logic [4:0] {
    PH_HDR, PH_NOTTLS, PH_STOP, PH_HS_TYPE, PH_HS_LEN, PH_VER, PH_RANDOM,
    PH_SID_LEN, PH_SID, PH_CS_LEN, PH_CS, PH_COMP_LEN, PH_COMP, PH_EXT_TOTAL,
    PH_EXT_HDR, PH_EXT_SKIP, PH_SNI_LIST, PH_SNI_TYPE, PH_SNI_NLEN,
    PH_SNI_NAME, PH_GRP_LEN, PH_GRP
  } phase_t;

  typedef struct packed {
    logic [15:0] id_first;
    logic [2:0]  lvl_first;
    logic [15:0] id_second;
    logic [2:0]  lvl_second;
    logic [15:0] id_third;
    logic [2:0]  lvl_third;
  } hyb_cfg_t;

  // one parsed byte: an optional event and an optional packet summary
  typedef struct packed {
    logic        ev_valid;
    kind_t       ev_kind;
    logic [15:0] ev_value;
    logic [2:0]  ev_level;
    logic        ev_sni_end;
    logic        sum_valid;
    logic [2:0]  sum_level;
    logic        is_tls;
    logic        is_hello;
    logic        hyb_seen;
    logic        complete;
  } entry_t;

endpackage

// File: design/tls_client_hello_parser.sv
`timescale 1ns / 1ps
// ClientHello inspector for a byte stream that starts at the TLS record header.
// in_*: one packet byte per request, in_tlast on the last byte of the packet.
// out_*: parse events (version, cipher suites, SNI bytes, matching hybrid
// groups) and, on the byte carrying in_tlast, a packet summary; out_tlast
// marks the last result caused by one input byte. A summary with
// record_complete low voids the events of that packet.
// cfg_*: writes of the three hybrid group ids and their levels, taken at
// any time with cfg_ready held high; write only while the block is idle.
// The front parser takes one byte per cycle while the queue is not full and
// writes its results into a small queue; the output stage drains one result
// per cycle while out_tready is high. The first result of an accepted byte is
// written to the queue and then to the output register. Bytes that cause two
// results (an event plus the summary) use one queue entry, split by the output stage.
// When out_tready is low the queue fills and in_tready drops once it is full;
// nothing is lost. Reset clears the parser to the record header phase, empties
// the queue and output, and restores the default hybrid ids and levels.
module tls_client_hello_parser #(
  parameter int QUEUE_DEPTH = tlsch_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [15:0] value, [18:16] level, [19] sni_end,
                                   // [20] is_tls, [21] hello_ok,
                                   // [22] hybrid_seen, [23] record_complete
  output logic [2:0]  out_tuser,   // [2:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tlsch_pkg::*;

  hyb_cfg_t cfg_r;
  logic     push;
  entry_t   push_entry;
  logic     full;
  logic     empty;
  logic     pop;
  entry_t   head;

  assign cfg_ready = 1'b1;
  assign in_tready = !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.id_first   <= HYB_ID_FIRST_RST;
      cfg_r.lvl_first  <= HYB_LVL_FIRST_RST;
      cfg_r.id_second  <= HYB_ID_SECOND_RST;
      cfg_r.lvl_second <= HYB_LVL_SECOND_RST;
      cfg_r.id_third   <= HYB_ID_THIRD_RST;
      cfg_r.lvl_third  <= HYB_LVL_THIRD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ID_FIRST:   cfg_r.id_first   <= cfg_data;
        REG_LVL_FIRST:  cfg_r.lvl_first  <= cfg_data[2:0];
        REG_ID_SECOND:  cfg_r.id_second  <= cfg_data;
        REG_LVL_SECOND: cfg_r.lvl_second <= cfg_data[2:0];
        REG_ID_THIRD:   cfg_r.id_third   <= cfg_data;
        REG_LVL_THIRD:  cfg_r.lvl_third  <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  tlsch_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_valid    (in_tvalid && in_tready),
    .data_byte     (in_tdata),
    .end_of_packet (in_tlast),
    .cfg           (cfg_r),
    .push          (push),
    .push_entry    (push_entry)
  );

  tlsch_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .head       (head)
  );

  tlsch_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: design/tlsch_front.sv
`timescale 1ns / 1ps
module tlsch_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        data_byte,
  input  logic              end_of_packet,
  input  tlsch_pkg::hyb_cfg_t cfg,
  output logic              push,
  output tlsch_pkg::entry_t push_entry
);
  import tlsch_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [5:0]  fbi_r, fbi_nxt;
  logic [15:0] record_left_r, record_left_nxt;
  logic [15:0] section_left_r, section_left_nxt;
  logic [15:0] ext_block_left_r, ext_block_left_nxt;
  logic [15:0] ext_left_r, ext_left_nxt;
  logic [15:0] sub_left_r, sub_left_nxt;
  logic [15:0] ext_id_r, ext_id_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [2:0]  max_level_r, max_level_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HDR;
      fbi_r            <= '0;
      record_left_r    <= '0;
      section_left_r   <= '0;
      ext_block_left_r <= '0;
      ext_left_r       <= '0;
      sub_left_r       <= '0;
      ext_id_r         <= '0;
      high_byte_r      <= '0;
      seen_r           <= '0;
      max_level_r      <= '0;
    end else begin
      phase_r          <= phase_nxt;
      fbi_r            <= fbi_nxt;
      record_left_r    <= record_left_nxt;
      section_left_r   <= section_left_nxt;
      ext_block_left_r <= ext_block_left_nxt;
      ext_left_r       <= ext_left_nxt;
      sub_left_r       <= sub_left_nxt;
      ext_id_r         <= ext_id_nxt;
      high_byte_r      <= high_byte_nxt;
      seen_r           <= seen_nxt;
      max_level_r      <= max_level_nxt;
    end
  end

  always_comb begin
    logic [15:0] word;
    logic [15:0] bval;
    logic [15:0] v;
    logic        do_fin;
    logic        do_next;
    logic        hit;
    logic [2:0]  lvl;
    logic        complete;

    word = {high_byte_r, data_byte};
    bval = {8'd0, data_byte};
    v = '0;
    do_fin = 1'b0;
    do_next = 1'b0;
    hit = 1'b0;
    lvl = '0;
    complete = 1'b0;

    phase_nxt          = phase_r;
    fbi_nxt            = fbi_r;
    record_left_nxt    = record_left_r;
    section_left_nxt   = section_left_r;
    ext_block_left_nxt = ext_block_left_r;
    ext_left_nxt       = ext_left_r;
    sub_left_nxt       = sub_left_r;
    ext_id_nxt         = ext_id_r;
    high_byte_nxt      = high_byte_r;
    seen_nxt           = seen_r;
    max_level_nxt      = max_level_r;

    push_entry = '0;
    push       = 1'b0;

    if (byte_valid) begin
      if (phase_r == PH_HDR) begin
        if (fbi_r == 6'd0 && data_byte != CONTENT_HANDSHAKE) begin
          phase_nxt = PH_NOTTLS;
        end else if (fbi_r == 6'd3) begin
          high_byte_nxt = data_byte;
        end else if (fbi_r == 6'd4) begin
          record_left_nxt = word;
          seen_nxt[0] = 1'b1;
          phase_nxt = (word != 16'd0) ? PH_HS_TYPE : PH_STOP;
        end
        fbi_nxt = fbi_r + 6'd1;
      end else if (phase_r != PH_NOTTLS && record_left_r != 16'd0) begin
        record_left_nxt = record_left_r - 16'd1;
        if (phase_r != PH_STOP) begin
          if (phase_r >= PH_EXT_HDR) begin
            ext_block_left_nxt = ext_block_left_r - 16'd1;
            if (phase_r != PH_EXT_HDR) ext_left_nxt = ext_left_r - 16'd1;
          end
          unique case (phase_r)
            PH_HS_TYPE: begin
              if (data_byte != HS_CLIENT_HELLO) phase_nxt = PH_STOP;
              else begin
                phase_nxt = PH_HS_LEN;
                fbi_nxt = '0;
              end
            end
            PH_HS_LEN: begin
              if (fbi_r == 6'd0) begin
                section_left_nxt = (data_byte != 8'd0) ? 16'hffff : 16'd0;
                fbi_nxt = 6'd1;
              end else if (fbi_r == 6'd1) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd2;
              end else begin
                v = (section_left_r == 16'hffff) ? 16'hffff : word;
                if (v > record_left_nxt) phase_nxt = PH_STOP;
                else begin
                  seen_nxt[1] = 1'b1;
                  phase_nxt = PH_VER;
                  fbi_nxt = '0;
                end
              end
            end
            PH_VER: begin
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else begin
                push_entry.ev_valid = 1'b1;
                push_entry.ev_kind  = KIND_VERSION;
                push_entry.ev_value = word;
                phase_nxt = PH_RANDOM;
                section_left_nxt = RANDOM_LEN;
              end
            end
            PH_RANDOM: begin
              section_left_nxt = section_left_r - 16'd1;
              if (section_left_nxt == 16'd0) phase_nxt = PH_SID_LEN;
            end
            PH_SID_LEN, PH_COMP_LEN: begin
              if (bval > record_left_nxt) phase_nxt = PH_STOP;
              else if (data_byte == 8'd0) begin
                phase_nxt = (phase_r == PH_SID_LEN) ? PH_CS_LEN : PH_EXT_TOTAL;
                fbi_nxt = '0;
              end else begin
                section_left_nxt = bval;
                phase_nxt = (phase_r == PH_SID_LEN) ? PH_SID : PH_COMP;
              end
            end
            PH_SID, PH_COMP: begin
              section_left_nxt = section_left_r - 16'd1;
              if (section_left_nxt == 16'd0) begin
                phase_nxt = (phase_r == PH_SID) ? PH_CS_LEN : PH_EXT_TOTAL;
                fbi_nxt = '0;
              end
            end
            PH_CS_LEN: begin
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else if (word > record_left_nxt) phase_nxt = PH_STOP;
              else if (word == 16'd0) phase_nxt = PH_COMP_LEN;
              else begin
                section_left_nxt = word;
                fbi_nxt = '0;
                phase_nxt = PH_CS;
              end
            end
            PH_CS: begin
              section_left_nxt = section_left_r - 16'd1;
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else begin
                push_entry.ev_valid = 1'b1;
                push_entry.ev_kind  = KIND_SUITE;
                push_entry.ev_value = word;
                fbi_nxt = '0;
              end
              if (section_left_nxt == 16'd0) phase_nxt = PH_COMP_LEN;
            end
            PH_EXT_TOTAL: begin
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else if (word > record_left_nxt) phase_nxt = PH_STOP;
              else begin
                ext_block_left_nxt = word;
                do_next = 1'b1;
              end
            end
            PH_EXT_HDR: begin
              if (fbi_r == 6'd0 || fbi_r == 6'd2) begin
                high_byte_nxt = data_byte;
                fbi_nxt = fbi_r + 6'd1;
              end else if (fbi_r == 6'd1) begin
                ext_id_nxt = word;
                fbi_nxt = 6'd2;
              end else begin
                ext_left_nxt = word;
                fbi_nxt = '0;
                if (word > ext_block_left_nxt) phase_nxt = PH_STOP;
                else if (ext_id_r == EXT_SERVER_NAME && word >= 16'd5)
                  phase_nxt = PH_SNI_LIST;
                else if (ext_id_r == EXT_GROUPS && word >= 16'd2)
                  phase_nxt = PH_GRP_LEN;
                else do_fin = 1'b1;
              end
            end
            PH_EXT_SKIP: begin
              if (ext_left_nxt == 16'd0) do_next = 1'b1;
            end
            PH_SNI_LIST: begin
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else if (word > ext_left_nxt || word < 16'd3) do_fin = 1'b1;
              else phase_nxt = PH_SNI_TYPE;
            end
            PH_SNI_TYPE: begin
              sub_left_nxt = bval;
              phase_nxt = PH_SNI_NLEN;
              fbi_nxt = '0;
            end
            PH_SNI_NLEN: begin
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else if (sub_left_r != 16'd0 || word > ext_left_nxt || word == 16'd0)
                do_fin = 1'b1;
              else begin
                sub_left_nxt = word;
                phase_nxt = PH_SNI_NAME;
              end
            end
            PH_SNI_NAME: begin
              sub_left_nxt = sub_left_r - 16'd1;
              push_entry.ev_valid   = 1'b1;
              push_entry.ev_kind    = KIND_SNI;
              push_entry.ev_value   = bval;
              push_entry.ev_sni_end = (sub_left_nxt == 16'd0);
              if (sub_left_nxt == 16'd0) do_fin = 1'b1;
            end
            PH_GRP_LEN: begin
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else if (word > ext_left_nxt || word < 16'd2) do_fin = 1'b1;
              else begin
                sub_left_nxt = word;
                fbi_nxt = '0;
                phase_nxt = PH_GRP;
              end
            end
            PH_GRP: begin
              sub_left_nxt = sub_left_r - 16'd1;
              if (fbi_r == 6'd0) begin
                high_byte_nxt = data_byte;
                fbi_nxt = 6'd1;
              end else begin
                // first matching configured id wins
                priority if (word == cfg.id_first) begin
                  hit = 1'b1;
                  lvl = cfg.lvl_first;
                end else if (word == cfg.id_second) begin
                  hit = 1'b1;
                  lvl = cfg.lvl_second;
                end else if (word == cfg.id_third) begin
                  hit = 1'b1;
                  lvl = cfg.lvl_third;
                end else begin
                  hit = 1'b0;
                end
                if (hit) begin
                  push_entry.ev_valid = 1'b1;
                  push_entry.ev_kind  = KIND_GROUP;
                  push_entry.ev_value = word;
                  push_entry.ev_level = lvl;
                  seen_nxt[2] = 1'b1;
                  if (lvl > max_level_r) max_level_nxt = lvl;
                end
                fbi_nxt = '0;
                if (sub_left_nxt < 16'd2) do_fin = 1'b1;
              end
            end
            default: begin
            end
          endcase

          if (do_fin) begin
            if (ext_left_nxt == 16'd0) do_next = 1'b1;
            else phase_nxt = PH_EXT_SKIP;
          end
          if (do_next) begin
            if (ext_block_left_nxt >= 16'd4) begin
              phase_nxt = PH_EXT_HDR;
              fbi_nxt = '0;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
        end
      end

      if (end_of_packet) begin
        complete = phase_nxt != PH_HDR && phase_nxt != PH_NOTTLS &&
                   record_left_nxt == 16'd0;
        push_entry.sum_valid  = 1'b1;
        push_entry.sum_level  = max_level_nxt;
        push_entry.is_tls     = seen_nxt[0];
        push_entry.is_hello   = seen_nxt[1];
        push_entry.hyb_seen   = seen_nxt[2];
        push_entry.complete   = complete;
        phase_nxt          = PH_HDR;
        fbi_nxt            = '0;
        record_left_nxt    = '0;
        section_left_nxt   = '0;
        ext_block_left_nxt = '0;
        ext_left_nxt       = '0;
        sub_left_nxt       = '0;
        ext_id_nxt         = '0;
        high_byte_nxt      = '0;
        seen_nxt           = '0;
        max_level_nxt      = '0;
      end
      push = push_entry.ev_valid | push_entry.sum_valid;
    end
  end

endmodule

// File: design/tlsch_queue.sv
`timescale 1ns / 1ps
module tlsch_queue #(
  parameter int DEPTH = tlsch_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tlsch_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output tlsch_pkg::entry_t head
);
  import tlsch_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (push && !pop) cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_entry;
  end

endmodule

// File: design/tlsch_back.sv
`timescale 1ns / 1ps
module tlsch_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              empty,
  input  tlsch_pkg::entry_t head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);
  import tlsch_pkg::*;

  logic        valid_r, valid_nxt;
  logic [23:0] data_r, data_nxt;
  logic [2:0]  user_r, user_nxt;
  logic        last_r, last_nxt;
  logic        pend_r, pend_nxt;
  entry_t      pend_e_r, pend_e_nxt;

  function automatic logic [23:0] sum_word(entry_t e);
    sum_word = {e.complete, e.hyb_seen, e.is_hello, e.is_tls, 1'b0,
                e.sum_level, 16'd0};
  endfunction

  always_comb begin
    logic load;
    load       = !valid_r || out_tready;
    valid_nxt  = valid_r && !out_tready;
    data_nxt   = data_r;
    user_nxt   = user_r;
    last_nxt   = last_r;
    pend_nxt   = pend_r;
    pend_e_nxt = pend_e_r;
    pop        = 1'b0;
    if (load) begin
      if (pend_r) begin
        // second result of a byte: its summary
        valid_nxt = 1'b1;
        data_nxt  = sum_word(pend_e_r);
        user_nxt  = KIND_SUMMARY;
        last_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end else if (!empty) begin
        pop       = 1'b1;
        valid_nxt = 1'b1;
        if (head.ev_valid) begin
          data_nxt   = {4'd0, head.ev_sni_end, head.ev_level, head.ev_value};
          user_nxt   = head.ev_kind;
          last_nxt   = !head.sum_valid;
          pend_nxt   = head.sum_valid;
          pend_e_nxt = head;
        end else begin
          data_nxt = sum_word(head);
          user_nxt = KIND_SUMMARY;
          last_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    user_r   <= user_nxt;
    last_r   <= last_nxt;
    pend_e_r <= pend_e_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule
